@@ sv/ratio_polynomial_range_calc_unit_defines.svh @@
`ifndef RATIO_POLYNOMIAL_RANGE_CALC_UNIT_DEFINES_SVH
`define RATIO_POLYNOMIAL_RANGE_CALC_UNIT_DEFINES_SVH

// same-cycle implication
`define RPRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RPRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rprc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rprc_pkg;

  typedef struct packed {
    logic signed [15:0] bottom_raw;
    logic signed [15:0] top_raw;
    logic [6:0]         pulse_count;
    logic [9:0]         temperature_code;
  } sample_t;

  typedef struct packed {
    logic [23:0] distance_cm;
    logic [39:0] reflectance;
    logic        sample_usable;
    logic        zero_pulses;
  } result_t;

  typedef enum logic [1:0] {
    KS_DIV,
    KS_ZERO,
    KS_ONES
  } ksel_t;

  typedef struct packed {
    logic [15:0]        sum;
    logic [6:0]         pulses;
    logic               calc;
    ksel_t              ksel;
    logic               usable_raw;
    logic [2:0]         variant;
    logic signed [11:0] tdiff;
  } side_t;

  localparam int SIDE_W        = $bits(side_t);
  localparam int NUM_VARIANTS  = 5;
  localparam int NUM_COEF      = 7;
  localparam int K_W           = 32;
  localparam int SUM_W         = 17;
  localparam int DIST_W        = 24;
  localparam int SQ_W          = 48;
  localparam int RDEN_W        = 11;
  localparam int DIV_STEPS_DEF = 2;
  localparam int ADDR_W        = 3;
  localparam int REG_SENSOR_VARIANT = 0;
  localparam logic [2:0] VARIANT_RESET = 3'd1;
  localparam logic [2:0] VARIANT_T     = 3'd4;

  // Q40.24 calibration sets, R J S K T
  localparam logic signed [63:0] COEF [NUM_VARIANTS][NUM_COEF] = '{
    '{  ((64'd1648001 << 24) + ((64'd258107309 << 24) + 64'd500000000) / 64'd1000000000),
       -((64'd5305835 << 24) + ((64'd891559632 << 24) + 64'd500000000) / 64'd1000000000),
        ((64'd7127857 << 24) + ((64'd366587162 << 24) + 64'd500000000) / 64'd1000000000),
       -((64'd5110547 << 24) + ((64'd144753641 << 24) + 64'd500000000) / 64'd1000000000),
        ((64'd2060999 << 24) + ((64'd435889212 << 24) + 64'd500000000) / 64'd1000000000),
       -((64'd442399 << 24) + ((64'd8603771256 << 24) + 64'd5000000000) / 64'd10000000000),
        ((64'd39387 << 24) + ((64'd15633389474 << 24) + 64'd50000000000)
          / 64'd100000000000) },
    '{ -((64'd70300600 << 24) + ((64'd13434869 << 24) + 64'd50000000) / 64'd100000000),
        ((64'd234093993 << 24) + ((64'd305397 << 24) + 64'd5000000) / 64'd10000000),
       -((64'd324489410 << 24) + ((64'd5718181 << 24) + 64'd5000000) / 64'd10000000),
        ((64'd239654657 << 24) + ((64'd4907680 << 24) + 64'd5000000) / 64'd10000000),
       -((64'd99462206 << 24) + ((64'd41072804 << 24) + 64'd50000000) / 64'd100000000),
        ((64'd21993376 << 24) + ((64'd93620224 << 24) + 64'd50000000) / 64'd100000000),
       -((64'd2024354 << 24) + ((64'd412459942 << 24) + 64'd500000000) / 64'd1000000000) },
    '{  ((64'd2004878860 << 24) + ((64'd926888 << 24) + 64'd500000) / 64'd1000000),
       -((64'd6155609773 << 24) + ((64'd756969 << 24) + 64'd500000) / 64'd1000000),
        ((64'd7872203128 << 24) + ((64'd922240 << 24) + 64'd500000) / 64'd1000000),
       -((64'd5367517768 << 24) + ((64'd838326 << 24) + 64'd500000) / 64'd1000000),
        ((64'd2057909512 << 24) + ((64'd255952 << 24) + 64'd500000) / 64'd1000000),
       -((64'd420658949 << 24) + ((64'd1410656 << 24) + 64'd5000000) / 64'd10000000),
        ((64'd35815718 << 24) + ((64'd64948885 << 24) + 64'd50000000) / 64'd100000000) },
    '{  ((64'd2147918 << 24) + ((64'd234375362 << 24) + 64'd500000000) / 64'd1000000000),
       -((64'd7736068 << 24) + ((64'd312640203 << 24) + 64'd500000000) / 64'd1000000000),
        ((64'd11544941 << 24) + ((64'd86428487 << 24) + 64'd50000000) / 64'd100000000),
       -((64'd9137795 << 24) + ((64'd412258314 << 24) + 64'd500000000) / 64'd1000000000),
        ((64'd4045684 << 24) + ((64'd724836031 << 24) + 64'd500000000) / 64'd1000000000),
       -((64'd949490 << 24) + ((64'd1699902674 << 24) + 64'd5000000000) / 64'd10000000000),
        ((64'd92195 << 24) + ((64'd99710241470 << 24) + 64'd50000000000)
          / 64'd100000000000) },
    '{ -((64'd653971 << 24) + ((64'd2337289967 << 24) + 64'd5000000000) / 64'd10000000000),
        ((64'd2522196 << 24) + ((64'd790614386 << 24) + 64'd500000000) / 64'd1000000000),
       -((64'd3966911 << 24) + ((64'd268599921 << 24) + 64'd500000000) / 64'd1000000000),
        ((64'd3266065 << 24) + ((64'd347655729 << 24) + 64'd500000000) / 64'd1000000000),
       -((64'd1487548 << 24) + ((64'd484816432 << 24) + 64'd500000000) / 64'd1000000000),
        ((64'd356376 << 24) + ((64'd1476000117 << 24) + 64'd5000000000) / 64'd10000000000),
       -((64'd35197 << 24) + ((64'd52184644648 << 24) + 64'd50000000000)
          / 64'd100000000000) }
  };

  localparam logic [9:0] STABLE_TENTHS [NUM_VARIANTS] = '{
    10'd480, 10'd460, 10'd470, 10'd440, 10'd460
  };

  localparam logic signed [23:0] SENS [NUM_VARIANTS] = '{
    24'(((64'd9623 << 24) + 64'd50000) / 64'd100000),
    24'(((64'd5623 << 24) + 64'd50000) / 64'd100000),
    24'(((64'd9623 << 24) + 64'd50000) / 64'd100000),
    24'(((64'd5623 << 24) + 64'd50000) / 64'd100000),
    24'(((64'd5623 << 24) + 64'd50000) / 64'd100000)
  };

endpackage

`default_nettype wire

@@ sv/rprc_div_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rprc_div_pipe #(
  parameter int NW  = 32,
  parameter int DW  = 17,
  parameter int SPS = 2,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [DW-1:0] rem,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);

  localparam int NS = NW / SPS;

  logic          v_r [NS];
  logic [NW-1:0] n_r [NS];
  logic [DW-1:0] r_r [NS];
  logic [DW-1:0] d_r [NS];
  logic [SW-1:0] s_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          v_in;
    logic [NW-1:0] n_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic [NW-1:0] n_next;
    logic [DW-1:0] r_next;
    logic [DW:0]   rs;

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign n_in = num;
      assign r_in = rem;
      assign d_in = den;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = v_r[s-1];
      assign n_in = n_r[s-1];
      assign r_in = r_r[s-1];
      assign d_in = d_r[s-1];
      assign s_in = s_r[s-1];
    end

    // restoring steps, quotient bits shift in as numerator bits shift out
    always_comb begin
      r_next = r_in;
      n_next = n_in;
      rs     = '0;
      for (int j = 0; j < SPS; j++) begin
        rs     = {r_next, n_next[NW-1]};
        n_next = {n_next[NW-2:0], 1'b0};
        if (rs >= {1'b0, d_in}) begin
          rs        = rs - {1'b0, d_in};
          n_next[0] = 1'b1;
        end
        r_next = rs[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s] <= n_next;
        r_r[s] <= r_next;
        d_r[s] <= d_in;
        s_r[s] <= s_in;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign quo       = n_r[NS-1];
  assign side_out  = s_r[NS-1];

endmodule

`default_nettype wire

@@ sv/rprc_horner.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rprc_horner (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [31:0]     k_quo,
  input  rprc_pkg::side_t in_side,
  output logic            out_valid,
  output logic [23:0]     range_cm,
  output rprc_pkg::side_t out_side
);

  import rprc_pkg::*;

  localparam int NSTEP = NUM_COEF - 1;

  logic [K_W-1:0]     k_sel;
  logic               h_valid;
  logic signed [63:0] h_acc;
  logic [K_W-1:0]     h_k;
  logic signed [35:0] h_tm;
  side_t              h_side;

  logic               a_valid [NSTEP];
  logic signed [64:0] a_hi    [NSTEP];
  logic [63:0]        a_lo    [NSTEP];
  logic [K_W-1:0]     a_k     [NSTEP];
  logic signed [35:0] a_tm    [NSTEP];
  side_t              a_side  [NSTEP];

  logic               b_valid [NSTEP];
  logic signed [63:0] b_acc   [NSTEP];
  logic [K_W-1:0]     b_k     [NSTEP];
  logic signed [35:0] b_tm    [NSTEP];
  side_t              b_side  [NSTEP];

  logic               f_valid;
  logic signed [63:0] f_acc;
  side_t              f_side;
  logic [DIST_W-1:0]  dist_next;

  always_comb begin
    case (in_side.ksel)
      KS_ZERO: k_sel = '0;
      KS_ONES: k_sel = '1;
      default: k_sel = k_quo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_acc  <= COEF[in_side.variant][0];
      h_k    <= k_sel;
      h_tm   <= 36'(in_side.tdiff) * 36'(SENS[in_side.variant]);
      h_side <= in_side;
    end
  end

  // one Horner step per pair of stages: split multiply, then add
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic               src_valid;
    logic signed [63:0] src_acc;
    logic [K_W-1:0]     src_k;
    logic signed [35:0] src_tm;
    side_t              src_side;

    if (i == 0) begin : g_first
      assign src_valid = h_valid;
      assign src_acc   = h_acc;
      assign src_k     = h_k;
      assign src_tm    = h_tm;
      assign src_side  = h_side;
    end else begin : g_next
      assign src_valid = b_valid[i-1];
      assign src_acc   = b_acc[i-1];
      assign src_k     = b_k[i-1];
      assign src_tm    = b_tm[i-1];
      assign src_side  = b_side[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_valid[i] <= 1'b0;
        b_valid[i] <= 1'b0;
      end else if (en) begin
        a_valid[i] <= src_valid;
        b_valid[i] <= a_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_hi[i]   <= $signed(src_acc[63:32]) * $signed({1'b0, src_k});
        a_lo[i]   <= 64'(src_acc[31:0]) * 64'(src_k);
        a_k[i]    <= src_k;
        a_tm[i]   <= src_tm;
        a_side[i] <= src_side;
        b_acc[i]  <= 64'(a_hi[i]) + $signed({32'b0, a_lo[i][63:32]})
                     + COEF[a_side[i].variant][i+1];
        b_k[i]    <= a_k[i];
        b_tm[i]   <= a_tm[i];
        b_side[i] <= a_side[i];
      end
    end
  end

  always_comb begin
    if (!f_side.calc || f_acc[63] || f_acc == '0) begin
      dist_next = '0;
    end else if (|f_acc[62:40]) begin
      dist_next = '1;
    end else begin
      dist_next = f_acc[39:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f_valid   <= b_valid[NSTEP-1];
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_acc    <= b_acc[NSTEP-1] + 64'(b_tm[NSTEP-1]);
      f_side   <= b_side[NSTEP-1];
      range_cm <= dist_next;
      out_side <= f_side;
    end
  end

endmodule

`default_nettype wire

@@ sv/rprc_refl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rprc_refl #(
  parameter int DIV_STEPS = rprc_pkg::DIV_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [23:0]       range_cm,
  input  rprc_pkg::side_t   in_side,
  output logic              out_valid,
  output rprc_pkg::result_t result
);

  import rprc_pkg::*;

  localparam int RS_W = DIST_W + SIDE_W;

  logic              r1_valid, r2_valid, r3_valid;
  logic [SQ_W-1:0]   r1_sq;
  logic [RDEN_W-1:0] r1_den, r2_den, r3_den;
  logic [DIST_W-1:0] r1_dist, r2_dist, r3_dist;
  side_t             r1_side, r2_side, r3_side;
  logic [SQ_W-1:0]   r2_lo;
  logic [31:0]       r2_hi;
  logic [SQ_W-1:0]   r3_n;

  logic              dv_valid;
  logic [SQ_W-1:0]   dv_quo;
  logic [RS_W-1:0]   dv_side;
  logic [DIST_W-1:0] q_dist;
  side_t             q_side;
  logic [39:0]       refl_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
      r2_valid <= 1'b0;
      r3_valid <= 1'b0;
    end else if (en) begin
      r1_valid <= in_valid;
      r2_valid <= r1_valid;
      r3_valid <= r2_valid;
    end
  end

  // d^2 * S, then drop 2^16 of the 10 * 2^16 * P divisor
  always_ff @(posedge clk) begin
    if (en) begin
      r1_sq   <= SQ_W'(range_cm) * SQ_W'(range_cm);
      r1_den  <= RDEN_W'(in_side.pulses) * RDEN_W'(10);
      r1_dist <= range_cm;
      r1_side <= in_side;
      r2_lo   <= SQ_W'(r1_sq[31:0]) * SQ_W'(r1_side.sum);
      r2_hi   <= 32'(r1_sq[47:32]) * 32'(r1_side.sum);
      r2_den  <= r1_den;
      r2_dist <= r1_dist;
      r2_side <= r1_side;
      r3_n    <= SQ_W'(({r2_hi, 32'b0} + 64'(r2_lo)) >> 16);
      r3_den  <= r2_den;
      r3_dist <= r2_dist;
      r3_side <= r2_side;
    end
  end

  rprc_div_pipe #(
    .NW  (SQ_W),
    .DW  (RDEN_W),
    .SPS (DIV_STEPS),
    .SW  (RS_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r3_valid),
    .num       (r3_n),
    .den       (r3_den),
    .rem       ('0),
    .side_in   ({r3_dist, r3_side}),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .side_out  (dv_side)
  );

  assign q_dist = dv_side[RS_W-1 -: DIST_W];
  assign q_side = side_t'(dv_side[SIDE_W-1:0]);

  always_comb begin
    if (q_dist == '0 || q_side.pulses == '0) begin
      refl_next = '0;
    end else if (|dv_quo[47:40]) begin
      refl_next = '1;
    end else begin
      refl_next = dv_quo[39:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.distance_cm   <= q_dist;
      result.reflectance   <= refl_next;
      result.sample_usable <= q_side.usable_raw && (q_dist != '0);
      result.zero_pulses   <= (q_side.pulses == '0);
    end
  end

endmodule

`default_nettype wire

@@ sv/ratio_polynomial_range_calc_unit.sv @@
// From sample word to result word: two input stages, 16-stage ratio
// divider, 15-stage Horner pipe, 3-stage product, 24-stage reflectance
// divider, output register. Throughput: one word per cycle;
// a stalled result freezes the whole pipe. Reset (rst, synchronous) clears
// all valid bits and sets sensor_variant to 1.
`timescale 1ns / 1ps
`default_nettype none
`include "ratio_polynomial_range_calc_unit_defines.svh"

module ratio_polynomial_range_calc_unit #(
  parameter int DIV_STEPS = rprc_pkg::DIV_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  rprc_pkg::sample_t           sample,
  output logic                        result_valid,
  input  logic                        result_stall,
  output rprc_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rprc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  import rprc_pkg::*;

  localparam logic [ADDR_W-1:0] REG_ADDR = ADDR_W'(REG_SENSOR_VARIANT * 4);

  logic              en;
  logic [2:0]        variant_r;

  logic              a_valid;
  sample_t           a_smp;
  logic [2:0]        a_var;

  logic signed [16:0] sum;
  logic signed [16:0] top_x;
  logic [16:0]        thr;
  side_t              side_next;

  logic              b_valid;
  side_t             b_side;
  logic [SUM_W-1:0]  b_den;
  logic [SUM_W-1:0]  b_rem;

  logic              kd_valid;
  logic [K_W-1:0]    kd_quo;
  logic [SIDE_W-1:0] kd_side;

  logic              hz_valid;
  logic [DIST_W-1:0] hz_dist;
  side_t             hz_side;

  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ADDR) ? 32'(variant_r) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant_r <= VARIANT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_ADDR) begin
      variant_r <= pwdata[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= sample_valid;
      b_valid <= a_valid;
    end
  end

  always_comb begin
    sum   = 17'(a_smp.bottom_raw) + 17'(a_smp.top_raw);
    top_x = 17'(a_smp.top_raw);
    thr   = 17'd100 + 17'({a_smp.pulse_count, 2'b00});
    side_next.sum    = sum[15:0];
    side_next.pulses = a_smp.pulse_count;
    side_next.calc   = (a_smp.bottom_raw >= 0) && (a_smp.bottom_raw <= 16'sd2400)
                       && (sum > $signed(thr));
    if (a_smp.top_raw < 0) begin
      side_next.ksel = KS_ZERO;
    end else if (top_x >= sum) begin
      side_next.ksel = KS_ONES;
    end else begin
      side_next.ksel = KS_DIV;
    end
    side_next.usable_raw = (a_smp.bottom_raw > 16'sd100) && (a_smp.top_raw > 16'sd100)
                           && (a_smp.bottom_raw < 16'sd2300) && (a_smp.top_raw < 16'sd2300);
    side_next.variant = a_var;
    side_next.tdiff   = $signed(12'(STABLE_TENTHS[a_var])) - $signed(12'(a_smp.temperature_code));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_smp  <= sample;
      a_var  <= (variant_r > VARIANT_T) ? VARIANT_T : variant_r;
      b_side <= side_next;
      b_den  <= sum;
      b_rem  <= {1'b0, a_smp.top_raw};
    end
  end

  // k = top * 2^32 / sum, only the fraction bits since top < sum
  rprc_div_pipe #(
    .NW  (K_W),
    .DW  (SUM_W),
    .SPS (DIV_STEPS),
    .SW  (SIDE_W)
  ) u_kdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .num       ('0),
    .den       (b_den),
    .rem       (b_rem),
    .side_in   (b_side),
    .out_valid (kd_valid),
    .quo       (kd_quo),
    .side_out  (kd_side)
  );

  rprc_horner u_horner (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (kd_valid),
    .k_quo     (kd_quo),
    .in_side   (side_t'(kd_side)),
    .out_valid (hz_valid),
    .range_cm  (hz_dist),
    .out_side  (hz_side)
  );

  rprc_refl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_refl (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (hz_valid),
    .range_cm  (hz_dist),
    .in_side   (hz_side),
    .out_valid (result_valid),
    .result    (result)
  );

  `RPRC_ASSERT_IMP(a_zero_dist_refl, result_valid && result.distance_cm == '0,
                   result.reflectance == '0, "reflectance set with zero distance")
  `RPRC_ASSERT_IMP(a_zero_pulse_refl, result_valid && result.zero_pulses,
                   result.reflectance == '0, "reflectance set with zero pulses")
  `RPRC_ASSERT_IMP(a_usable_dist, result_valid && result.sample_usable,
                   result.distance_cm != '0, "usable sample without distance")
  `RPRC_ASSERT_NXT(a_cfg_write, psel && penable && pwrite && paddr == REG_ADDR,
                   variant_r == $past(pwdata[2:0]), "sensor_variant write lost")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rprc_pkg::*;

  localparam int LATENCY     = 61;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ratio_polynomial_range_calc_unit uut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sample_t pending_samples[$];
  result_t range_expect_q[$];
  logic [2:0] variant_copy = VARIANT_RESET;
  int errors = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int usable_seen = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int long_hold = 0;
  bit hold_request = 0;
  bit send_burst = 0;
  bit recv_burst = 0;

  // a * k / 2^32, k in Q0.32, floor
  function automatic longint frac_scale(longint a, bit [31:0] k);
    bit [63:0] m;
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] q;
    bit neg;
    neg = a < 0;
    m = neg ? 64'(-a) : 64'(a);
    hi = (m >> 32) * 64'(k);
    lo = (m & 64'hFFFF_FFFF) * 64'(k);
    q = hi + (lo >> 32);
    if (neg) begin
      if (lo[31:0] != 0) q = q + 1;
      return -longint'(q);
    end
    return longint'(q);
  endfunction

  function automatic result_t predict_range(sample_t s, logic [2:0] var_code);
    int bot;
    int top;
    int sum;
    int p;
    int v;
    longint acc;
    bit [31:0] k;
    bit [63:0] num;
    bit [63:0] d;
    bit [63:0] refl;
    result_t r;
    bot = s.bottom_raw;
    top = s.top_raw;
    sum = bot + top;
    p = s.pulse_count;
    v = (var_code > VARIANT_T) ? 4 : var_code;
    d = 0;
    refl = 0;
    if (bot >= 0 && bot <= 2400 && sum > 100 + 4 * p) begin
      if (top < 0) k = 0;
      else if (top >= sum) k = 32'hFFFF_FFFF;
      else begin
        num = {32'(top), 32'd0};
        k = 32'(num / 64'(sum));
      end
      acc = COEF[v][0];
      for (int i = 1; i < NUM_COEF; i++) acc = frac_scale(acc, k) + COEF[v][i];
      acc = acc + (longint'(STABLE_TENTHS[v]) - longint'(s.temperature_code))
                  * longint'(SENS[v]);
      if (acc > 0) begin
        d = 64'(acc) >> 16;
        if (d > 64'hFF_FFFF) d = 64'hFF_FFFF;
      end
    end
    if (d != 0 && p != 0) begin
      refl = (d * d * 64'(sum)) / (64'd655360 * 64'(p));
      if (refl > 64'hFF_FFFF_FFFF) refl = 64'hFF_FFFF_FFFF;
    end
    r.distance_cm = d[23:0];
    r.reflectance = refl[39:0];
    r.sample_usable = bot > 100 && top > 100 && bot < 2300 && top < 2300 && d != 0;
    r.zero_pulses = (p == 0);
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        range_expect_q = {range_expect_q, predict_range(sample, variant_copy)};
        samples_sent++;
        if ($urandom_range(0, 40) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 10);
      end
      if (!sample_valid || !sample_stall) begin
        if (send_gap == 0 && pending_samples.size() > 0) begin
          sample <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (range_expect_q.size() == 0) begin
          errors++;
          $display("%0t unexpected word: actual %h", $time, result);
        end else begin
          want = range_expect_q.pop_front();
          if (result.sample_usable) usable_seen++;
          if (result.distance_cm !== want.distance_cm) begin
            errors++;
            $display("%0t distance_cm: expected %h actual %h", $time,
                     want.distance_cm, result.distance_cm);
          end
          if (result.reflectance !== want.reflectance) begin
            errors++;
            $display("%0t reflectance: expected %h actual %h", $time,
                     want.reflectance, result.reflectance);
          end
          if (result.sample_usable !== want.sample_usable) begin
            errors++;
            $display("%0t sample_usable: expected %b actual %b", $time,
                     want.sample_usable, result.sample_usable);
          end
          if (result.zero_pulses !== want.zero_pulses) begin
            errors++;
            $display("%0t zero_pulses: expected %b actual %b", $time,
                     want.zero_pulses, result.zero_pulses);
          end
        end
        if ($urandom_range(0, 40) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 10);
      end
      if (hold_request) begin
        hold_request = 0;
        long_hold = 400;
      end
      if (long_hold > 0) begin
        long_hold--;
        result_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[ratio_polynomial_range_calc_unit] ERROR");
      $finish;
    end
  end

  task automatic write_variant(logic [2:0] code);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(4 * REG_SENSOR_VARIANT);
    pwdata <= 32'(code);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    variant_copy = code;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || sample_valid || range_expect_q.size() > 0)
      @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic add_sample(int bot, int top, int p, int t);
    sample_t s;
    s.bottom_raw = 16'(bot);
    s.top_raw = 16'(top);
    s.pulse_count = 7'(p);
    s.temperature_code = 10'(t);
    pending_samples = {pending_samples, s};
  endtask

  task automatic add_random_sample();
    int bot;
    int p;
    p = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) begin
      add_sample($urandom_range(0, 65535), $urandom_range(0, 65535), p,
                 $urandom_range(0, 1023));
    end else begin
      bot = $urandom_range(0, 2400);
      add_sample(bot, $urandom_range(0, 2700) - 150, p,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, 655));
    end
  endtask

  initial begin
    logic [2:0] plan [8] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd4, 3'd7, 3'd5, 3'd6};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_sample(0, 0, 0, 0);
    add_sample(2400, 32767, 99, 655);
    add_sample(2401, 500, 10, 300);
    add_sample(-32768, -32768, 127, 1023);
    add_sample(32767, 32767, 0, 0);
    add_sample(1000, -200, 5, 460);
    add_sample(50, 1200, 0, 460);
    add_sample(1200, 1200, 0, 460);
    add_sample(60, 80, 10, 400);
    add_sample(60, 81, 10, 400);
    add_sample(1200, 0, 20, 460);
    add_sample(0, 1500, 20, 460);
    add_sample(101, 101, 1, 1023);
    add_sample(2299, 2299, 1, 0);
    add_sample(100, 2300, 50, 500);
    add_sample(2400, -2300, 0, 655);
    add_sample(800, 1600, 99, 480);
    add_sample(1600, 800, 127, 200);
    add_sample(1200, 1100, 64, 768);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_variant(plan[ph]);
      @(negedge clk);
      if (ph == 3) hold_request = 1;
      for (int n = 0; n < 85; n++) add_random_sample();
      wait_drained();
    end

    if (range_expect_q.size() != 0) errors++;
    $display("Covered %0d samples over variant codes 0 to 7, %0d results, %0d usable.",
             samples_sent, results_seen, usable_seen);
    if (errors == 0) begin
      $display("[ratio_polynomial_range_calc_unit] OK");
    end else begin
      $display("[ratio_polynomial_range_calc_unit] ERROR");
    end
    $finish;
  end

endmodule
